// ===== rtl/core/ple_pkg.sv =====
// ----------------------------------------------------------------------------
// ple_pkg: shared definitions for the positional list engine
// Request and status codes, storage sizes and controller/datapath interfaces.
// ----------------------------------------------------------------------------
package ple_pkg;

   localparam int DEPTH  = 64;
   localparam int ADDR_W = $clog2(DEPTH);
   localparam int CNT_W  = 7;
   localparam int POS_W  = 7;
   localparam int REC_W  = 32;

   // request kinds
   localparam logic [1:0] REQ_INSERT = 2'd0;
   localparam logic [1:0] REQ_REMOVE = 2'd1;
   localparam logic [1:0] REQ_GET    = 2'd2;
   localparam logic [1:0] REQ_CLEAR  = 2'd3;

   // result status codes
   localparam logic [1:0] ST_OK     = 2'd0;
   localparam logic [1:0] ST_EMPTY  = 2'd1;
   localparam logic [1:0] ST_BADPOS = 2'd2;
   localparam logic [1:0] ST_FULL   = 2'd3;

   // controller -> datapath
   typedef struct packed {
      logic capture;    // latch the accepted request
      logic eval;       // latch status, seed the shift pointer
      logic rd_shift;   // read the entry to be moved
      logic wr_shift;   // write the moved entry, step the pointer
      logic put_word;   // write the new word for insert
      logic rd_get;     // read the entry for get
      logic finish;     // load the response register, update count
   } ple_cmd_type;

   // datapath -> controller
   typedef struct packed {
      logic       ok;         // request is legal against the current count
      logic [1:0] kind;
      logic       shift_more; // entries left to move
      logic       rsp_free;   // response register can take a new result
   } ple_sts_type;

endpackage

// ===== rtl/core/ple_ctrl.sv =====
// ----------------------------------------------------------------------------
// ple_ctrl: sequencer of the positional list engine
// Steps one request through check, entry shifting and response hand-off.
// ----------------------------------------------------------------------------
module ple_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  ple_pkg::ple_sts_type sts,
   output ple_pkg::ple_cmd_type cmd
);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_EVAL = 3'd1;
   localparam logic [2:0] S_LOOP = 3'd2;
   localparam logic [2:0] S_WR   = 3'd3;
   localparam logic [2:0] S_PUT  = 3'd4;
   localparam logic [2:0] S_GETR = 3'd5;
   localparam logic [2:0] S_DONE = 3'd6;

   logic [2:0] state_ff, state_in;

   assign req_stall = (state_ff != S_IDLE);

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_EVAL;
            end
         end
         S_EVAL: begin
            cmd.eval = 1'b1;
            if (!sts.ok || sts.kind == ple_pkg::REQ_CLEAR) begin
               state_in = S_DONE;
            end else if (sts.kind == ple_pkg::REQ_GET) begin
               state_in = S_GETR;
            end else begin
               state_in = S_LOOP;
            end
         end
         S_LOOP: begin
            if (sts.shift_more) begin
               cmd.rd_shift = 1'b1;
               state_in     = S_WR;
            end else if (sts.kind == ple_pkg::REQ_INSERT) begin
               state_in = S_PUT;
            end else begin
               state_in = S_DONE;
            end
         end
         S_WR: begin
            cmd.wr_shift = 1'b1;
            state_in     = S_LOOP;
         end
         S_PUT: begin
            cmd.put_word = 1'b1;
            state_in     = S_DONE;
         end
         S_GETR: begin
            cmd.rd_get = 1'b1;
            state_in   = S_DONE;
         end
         S_DONE: begin
            if (sts.rsp_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

endmodule

// ===== rtl/core/ple_dp.sv =====
// ----------------------------------------------------------------------------
// ple_dp: datapath of the positional list engine
// Entry memory, count, shift pointer, request checks and response register.
// ----------------------------------------------------------------------------
module ple_dp (
   input  logic                             clock,
   input  logic                             reset,
   input  logic [1:0]                       req_type,
   input  logic [ple_pkg::POS_W-1:0]        req_position,
   input  logic [ple_pkg::REC_W-1:0]        req_record_in,
   input  ple_pkg::ple_cmd_type             cmd,
   output ple_pkg::ple_sts_type             sts,
   input  logic                             rsp_stall,
   output logic                             rsp_valid,
   output logic [1:0]                       rsp_status,
   output logic [ple_pkg::REC_W-1:0]        rsp_record_out,
   output logic [ple_pkg::CNT_W-1:0]        rsp_entry_count,
   output logic                             rsp_is_empty
);

   logic [ple_pkg::REC_W-1:0]  mem [ple_pkg::DEPTH];

   logic [1:0]                 kind_ff, kind_in;
   logic [ple_pkg::POS_W-1:0]  pos_ff, pos_in;
   logic [ple_pkg::REC_W-1:0]  word_ff, word_in;
   logic [ple_pkg::REC_W-1:0]  rd_data_ff;
   logic [1:0]                 st_ff, st_in, st_cmb;
   logic [ple_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [ple_pkg::CNT_W-1:0]  ptr_ff, ptr_in;

   logic                       rsp_valid_ff, rsp_valid_in;
   logic [1:0]                 rsp_status_ff;
   logic [ple_pkg::REC_W-1:0]  rsp_record_ff;
   logic [ple_pkg::CNT_W-1:0]  rsp_count_ff;
   logic                       rsp_empty_ff;

   logic                       is_ins;
   logic [ple_pkg::CNT_W-1:0]  count_p1, ptr_dec, ptr_inc;
   logic [ple_pkg::POS_W-1:0]  pos_m1;
   logic [ple_pkg::ADDR_W-1:0] rd_addr, wr_addr;
   logic                       wr_en;
   logic [ple_pkg::REC_W-1:0]  wr_data;

   assign is_ins   = (kind_ff == ple_pkg::REQ_INSERT);
   assign count_p1 = count_ff + ple_pkg::CNT_W'(1);
   assign ptr_dec  = ptr_ff - ple_pkg::CNT_W'(1);
   assign ptr_inc  = ptr_ff + ple_pkg::CNT_W'(1);
   assign pos_m1   = pos_ff - ple_pkg::POS_W'(1);

   // legality check against the current count
   always_comb begin
      st_cmb = ple_pkg::ST_OK;
      unique case (kind_ff) inside
         ple_pkg::REQ_INSERT: begin
            if (pos_ff == '0 || pos_ff > count_p1) begin
               st_cmb = ple_pkg::ST_BADPOS;
            end else if (count_ff == ple_pkg::CNT_W'(ple_pkg::DEPTH)) begin
               st_cmb = ple_pkg::ST_FULL;
            end
         end
         ple_pkg::REQ_REMOVE, ple_pkg::REQ_GET: begin
            if (count_ff == '0) begin
               st_cmb = ple_pkg::ST_EMPTY;
            end else if (pos_ff == '0 || pos_ff > count_ff) begin
               st_cmb = ple_pkg::ST_BADPOS;
            end
         end
         default: begin
            st_cmb = ple_pkg::ST_OK;
         end
      endcase
   end

   // insert walks down from count, remove walks up from pos
   assign sts.ok         = (st_cmb == ple_pkg::ST_OK);
   assign sts.kind       = kind_ff;
   assign sts.shift_more = is_ins ? (ptr_ff >= pos_ff) : (ptr_ff < count_ff);
   assign sts.rsp_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      if (cmd.rd_get) begin
         rd_addr = pos_m1[ple_pkg::ADDR_W-1:0];
      end else if (is_ins) begin
         rd_addr = ptr_dec[ple_pkg::ADDR_W-1:0];
      end else begin
         rd_addr = ptr_ff[ple_pkg::ADDR_W-1:0];
      end
      if (cmd.put_word) begin
         wr_addr = pos_m1[ple_pkg::ADDR_W-1:0];
         wr_data = word_ff;
      end else if (is_ins) begin
         wr_addr = ptr_ff[ple_pkg::ADDR_W-1:0];
         wr_data = rd_data_ff;
      end else begin
         wr_addr = ptr_dec[ple_pkg::ADDR_W-1:0];
         wr_data = rd_data_ff;
      end
      wr_en = cmd.put_word || cmd.wr_shift;
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (cmd.rd_shift || cmd.rd_get) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   always_comb begin
      kind_in = cmd.capture ? req_type      : kind_ff;
      pos_in  = cmd.capture ? req_position  : pos_ff;
      word_in = cmd.capture ? req_record_in : word_ff;
      st_in   = cmd.eval    ? st_cmb        : st_ff;

      ptr_in = ptr_ff;
      if (cmd.eval) begin
         ptr_in = is_ins ? count_ff : pos_ff;
      end else if (cmd.wr_shift) begin
         ptr_in = is_ins ? ptr_dec : ptr_inc;
      end

      count_in = count_ff;
      if (st_ff == ple_pkg::ST_OK) begin
         case (kind_ff)
            ple_pkg::REQ_INSERT: count_in = count_p1;
            ple_pkg::REQ_REMOVE: count_in = count_ff - ple_pkg::CNT_W'(1);
            ple_pkg::REQ_CLEAR:  count_in = '0;
            default:             count_in = count_ff;
         endcase
      end

      rsp_valid_in = rsp_valid_ff;
      if (cmd.finish) begin
         rsp_valid_in = 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      kind_ff <= kind_in;
      pos_ff  <= pos_in;
      word_ff <= word_in;
      st_ff   <= st_in;
      ptr_ff  <= ptr_in;
      if (cmd.finish) begin
         rsp_status_ff <= st_ff;
         rsp_record_ff <= (kind_ff == ple_pkg::REQ_GET && st_ff == ple_pkg::ST_OK) ?
                          rd_data_ff : '0;
         rsp_count_ff  <= count_in;
         rsp_empty_ff  <= (count_in == '0);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (cmd.finish) begin
            count_ff <= count_in;
         end
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_record_out  = rsp_record_ff;
   assign rsp_entry_count = rsp_count_ff;
   assign rsp_is_empty    = rsp_empty_ff;

endmodule

// ===== rtl/core/positional_list_engine_unit.sv =====
// ----------------------------------------------------------------------------
// positional_list_engine_unit: ordered list of record words, one-based
// Insert, remove, get and clear by position over a 64-entry list.
// ----------------------------------------------------------------------------
// One request is handled at a time; each gives exactly one response
// transaction. The list lives in a single-port-write, single-port-read
// memory with a registered read, so every entry moved to open or close a
// gap costs a read and a write. A new request is taken while the previous
// response still waits on rsp_stall; the engine only holds off at the point
// where it must load the next response. No clearing pass follows reset: the
// count alone decides which entries are live.
// ----------------------------------------------------------------------------
module positional_list_engine_unit (
   input  logic                      clock,
   input  logic                      reset,
   // request channel
   input  logic                      req_valid,
   output logic                      req_stall,
   input  logic [1:0]                req_type,
   input  logic [ple_pkg::POS_W-1:0] req_position,
   input  logic [ple_pkg::REC_W-1:0] req_record_in,
   // response channel
   output logic                      rsp_valid,
   input  logic                      rsp_stall,
   output logic [1:0]                rsp_status,
   output logic [ple_pkg::REC_W-1:0] rsp_record_out,
   output logic [ple_pkg::CNT_W-1:0] rsp_entry_count,
   output logic                      rsp_is_empty
);

   // command and status between the sequencer and the datapath
   ple_pkg::ple_cmd_type cmd;
   ple_pkg::ple_sts_type sts;

   // sequencer: accepts only in its idle state, walks the shift loop
   ple_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // datapath: entry memory, count, position checks, response register
   ple_dp u_dp (
      .clock           (clock),
      .reset           (reset),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_record_in   (req_record_in),
      .cmd             (cmd),
      .sts             (sts),
      .rsp_stall       (rsp_stall),
      .rsp_valid       (rsp_valid),
      .rsp_status      (rsp_status),
      .rsp_record_out  (rsp_record_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

endmodule

// ===== rtl/core/ple_checker.sv =====
// ----------------------------------------------------------------------------
// ple_checker: port-level assertions for the positional list engine
// Watches the response channel of the top level; bound in below.
// ----------------------------------------------------------------------------
module ple_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_stall,
   input logic [1:0]                rsp_status,
   input logic [ple_pkg::REC_W-1:0] rsp_record_out,
   input logic [ple_pkg::CNT_W-1:0] rsp_entry_count,
   input logic                      rsp_is_empty
);

   // stalled response transaction holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_status) &&
      $stable(rsp_record_out) && $stable(rsp_entry_count))
      else $error("stalled response changed");

   a_empty_flag: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_is_empty == (rsp_entry_count == '0))
      else $error("empty flag disagrees with count");

   a_err_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status != ple_pkg::ST_OK |-> rsp_record_out == '0)
      else $error("record data on failed request");

   a_count_max: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_entry_count <= ple_pkg::CNT_W'(ple_pkg::DEPTH))
      else $error("count above depth");

   // full is only possible with a full list
   a_full_count: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_status == ple_pkg::ST_FULL |->
      rsp_entry_count == ple_pkg::CNT_W'(ple_pkg::DEPTH))
      else $error("full status below depth");

endmodule

bind positional_list_engine_unit ple_checker u_ple_checker (
   .clock           (clock),
   .reset           (reset),
   .rsp_valid       (rsp_valid),
   .rsp_stall       (rsp_stall),
   .rsp_status      (rsp_status),
   .rsp_record_out  (rsp_record_out),
   .rsp_entry_count (rsp_entry_count),
   .rsp_is_empty    (rsp_is_empty)
);

// ===== test/positional_list_engine_unit_test.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// positional_list_engine_unit_test: self-checking bench for the list engine
// A short directed table (empty, bad positions, full list, clear) and then
// about 1200 random requests built to move the fill level between empty and
// full. Each accepted request runs through a local list predictor. Every
// response transaction is checked field by field, in order, against it or,
// for typed table rows, against the row's own expected value.
module positional_list_engine_unit_test;

   localparam int RANDOM_ITEMS = 1200;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int DRAIN_CYCLES = 200;    // longer than the slowest insert
   localparam int REPORT_MAX   = 10;

   typedef struct packed {
      logic [1:0]                status;
      logic [ple_pkg::REC_W-1:0] record;
      logic [ple_pkg::CNT_W-1:0] count;
      logic                      empty;
   } list_result_type;

   // one row of the directed table
   typedef struct packed {
      logic [1:0]                kind;
      logic [ple_pkg::POS_W-1:0] pos;
      logic [ple_pkg::REC_W-1:0] word;
      logic                      fill_first; // pack the list to DEPTH before this row
      logic                      typed;      // use the expected value below
      list_result_type           result;
   } list_row_type;

   logic                       clock           = 1'b0;
   logic                       reset           = 1'b1;
   logic                       req_valid       = 1'b0;
   logic [1:0]                 req_type        = ple_pkg::REQ_CLEAR;
   logic [ple_pkg::POS_W-1:0]  req_position    = '0;
   logic [ple_pkg::REC_W-1:0]  req_record_in   = '0;
   logic                       rsp_stall       = 1'b0;
   logic                       req_stall;
   logic                       rsp_valid;
   logic [1:0]                 rsp_status;
   logic [ple_pkg::REC_W-1:0]  rsp_record_out;
   logic [ple_pkg::CNT_W-1:0]  rsp_entry_count;
   logic                       rsp_is_empty;

   // local copy of the list, updated as requests are accepted
   logic [ple_pkg::REC_W-1:0]  list_words [ple_pkg::DEPTH];
   int                         list_count    = 0;

   list_result_type   awaited_responses [$];
   list_row_type      directed_rows [$];
   int                mismatch_count = 0;
   int                cycle_count    = 0;
   int                send_idle_pct  = 7;
   int                rcv_stall_pct  = 82;

   positional_list_engine_unit uut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_type        (req_type),
      .req_position    (req_position),
      .req_record_in   (req_record_in),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_status      (rsp_status),
      .rsp_record_out  (rsp_record_out),
      .rsp_entry_count (rsp_entry_count),
      .rsp_is_empty    (rsp_is_empty)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Apply one request to the local list and return the response it gives.
   // Insert checks the position before the full condition; remove and get
   // report an empty list before looking at the position.
   function automatic list_result_type apply_list_op(input logic [1:0] kind, input int pos,
                                                     input logic [ple_pkg::REC_W-1:0] word);
      list_result_type r;
      int              i;
      r.status = ple_pkg::ST_OK;
      r.record = '0;
      case (kind)
         ple_pkg::REQ_INSERT: begin
            if (pos < 1 || pos > list_count + 1) begin
               r.status = ple_pkg::ST_BADPOS;
            end else if (list_count >= ple_pkg::DEPTH) begin
               r.status = ple_pkg::ST_FULL;
            end else begin
               for (i = list_count; i >= pos; i--) list_words[i] = list_words[i - 1];
               list_words[pos - 1] = word;
               list_count++;
            end
         end
         ple_pkg::REQ_REMOVE: begin
            if (list_count == 0) begin
               r.status = ple_pkg::ST_EMPTY;
            end else if (pos < 1 || pos > list_count) begin
               r.status = ple_pkg::ST_BADPOS;
            end else begin
               for (i = pos; i < list_count; i++) list_words[i - 1] = list_words[i];
               list_count--;
            end
         end
         ple_pkg::REQ_GET: begin
            if (list_count == 0) begin
               r.status = ple_pkg::ST_EMPTY;
            end else if (pos < 1 || pos > list_count) begin
               r.status = ple_pkg::ST_BADPOS;
            end else begin
               r.record = list_words[pos - 1];
            end
         end
         default: begin
            list_count = 0;
         end
      endcase
      r.count = ple_pkg::CNT_W'(list_count);
      r.empty = (list_count == 0);
      return r;
   endfunction

   // Build one directed row and append it to the table.
   function automatic void add_row(input logic [1:0] kind, input int pos,
                                   input logic [ple_pkg::REC_W-1:0] word,
                                   input bit fill_first, input bit typed,
                                   input logic [1:0] status, input int count);
      list_row_type r;
      r.kind          = kind;
      r.pos           = ple_pkg::POS_W'(pos);
      r.word          = word;
      r.fill_first    = fill_first;
      r.typed         = typed;
      r.result.status = status;
      r.result.record = '0;
      r.result.count  = ple_pkg::CNT_W'(count);
      r.result.empty  = (count == 0);
      directed_rows.push_back(r);
   endfunction

   // Present one request transaction and hold it until the engine takes it.
   // Random idle cycles go in front; valid never looks at req_stall.
   task automatic send_request(input logic [1:0] kind, input int pos,
                               input logic [ple_pkg::REC_W-1:0] word, input bit typed,
                               input list_result_type typed_result);
      list_result_type predicted;
      while ($urandom_range(0, 99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_type      <= kind;
      req_position  <= ple_pkg::POS_W'(pos);
      req_record_in <= word;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      // accepted at this edge
      predicted = apply_list_op(kind, pos, word);
      awaited_responses.push_back(typed ? typed_result : predicted);
   endtask

   // Random request with the insert/remove mix pulled toward a fill target,
   // so the list spends time near empty, near full and in between.
   task automatic send_random_request(input int fill_target);
      int                        roll;
      int                        pos;
      logic [1:0]                kind;
      logic [ple_pkg::REC_W-1:0] word;
      roll = $urandom_range(0, 199);
      if (roll == 0) begin
         kind = ple_pkg::REQ_CLEAR;
      end else if (roll < 45) begin
         kind = ple_pkg::REQ_GET;
      end else if (list_count < fill_target) begin
         kind = (roll < 170) ? ple_pkg::REQ_INSERT : ple_pkg::REQ_REMOVE;
      end else if (list_count > fill_target) begin
         kind = (roll < 170) ? ple_pkg::REQ_REMOVE : ple_pkg::REQ_INSERT;
      end else begin
         kind = roll[0] ? ple_pkg::REQ_INSERT : ple_pkg::REQ_REMOVE;
      end

      // mostly legal positions, some noise across the whole field
      if ($urandom_range(0, 99) < 12) begin
         pos = $urandom_range(0, 127);
      end else if (kind == ple_pkg::REQ_INSERT) begin
         pos = $urandom_range(1, list_count + 1);
      end else if (list_count == 0) begin
         pos = $urandom_range(0, 127);
      end else begin
         pos = $urandom_range(1, list_count);
      end

      roll = $urandom_range(0, 9);
      word = (roll == 0) ? '0 : (roll == 1) ? '1 : ple_pkg::REC_W'($urandom);
      send_request(kind, pos, word, 1'b0, '0);
   endtask

   // Response side: check each accepted response transaction against the
   // oldest expectation, then pick the stall for the next cycle.
   always @(posedge clock) begin
      list_result_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_responses.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= REPORT_MAX)
               $display("unexpected response: status %0d record %h count %0d empty %0d",
                        rsp_status, rsp_record_out, rsp_entry_count, rsp_is_empty);
         end else begin
            want = awaited_responses.pop_front();
            if (rsp_status !== want.status || rsp_record_out !== want.record ||
                rsp_entry_count !== want.count || rsp_is_empty !== want.empty) begin
               mismatch_count++;
               if (mismatch_count <= REPORT_MAX)
                  $display("response mismatch: expected %0d/%h/%0d/%0d got %0d/%h/%0d/%0d",
                           want.status, want.record, want.count, want.empty,
                           rsp_status, rsp_record_out, rsp_entry_count, rsp_is_empty);
            end
         end
      end
      rsp_stall <= ($urandom_range(0, 99) < rcv_stall_pct);
   end

   // watchdog
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Verification failed");
         $finish;
      end
   end

   initial begin
      list_row_type r;
      int           fill_target;
      int           n;

      // empty list, bad positions on either side of the legal range
      add_row(ple_pkg::REQ_GET,    1,   '1,            0, 1, ple_pkg::ST_EMPTY,  0);
      add_row(ple_pkg::REQ_REMOVE, 0,   '0,            0, 1, ple_pkg::ST_EMPTY,  0);
      add_row(ple_pkg::REQ_INSERT, 0,   32'h1234_5678, 0, 1, ple_pkg::ST_BADPOS, 0);
      add_row(ple_pkg::REQ_INSERT, 2,   32'h1234_5678, 0, 1, ple_pkg::ST_BADPOS, 0);
      add_row(ple_pkg::REQ_INSERT, 1,   '1,            0, 1, ple_pkg::ST_OK,     1);
      add_row(ple_pkg::REQ_INSERT, 1,   '0,            0, 1, ple_pkg::ST_OK,     2);
      add_row(ple_pkg::REQ_INSERT, 3,   32'hA5A5_A5A5, 0, 0, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_INSERT, 2,   32'h5A5A_5A5A, 0, 0, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_GET,    0,   '0,            0, 1, ple_pkg::ST_BADPOS, 4);
      add_row(ple_pkg::REQ_GET,    5,   '0,            0, 1, ple_pkg::ST_BADPOS, 4);
      add_row(ple_pkg::REQ_GET,    127, '1,            0, 1, ple_pkg::ST_BADPOS, 4);
      add_row(ple_pkg::REQ_GET,    1,   '0,            0, 0, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_REMOVE, 5,   '0,            0, 1, ple_pkg::ST_BADPOS, 4);
      add_row(ple_pkg::REQ_REMOVE, 2,   '0,            0, 0, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_GET,    2,   '0,            0, 0, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_REMOVE, 3,   '0,            0, 0, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_CLEAR,  127, '1,            0, 1, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_CLEAR,  0,   '0,            0, 1, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_GET,    127, '0,            0, 1, ple_pkg::ST_EMPTY,  0);
      // full list: position is checked before the full condition
      add_row(ple_pkg::REQ_INSERT, 1,   '1, 1, 1, ple_pkg::ST_FULL,   ple_pkg::DEPTH);
      add_row(ple_pkg::REQ_INSERT, 65,  '1, 0, 1, ple_pkg::ST_FULL,   ple_pkg::DEPTH);
      add_row(ple_pkg::REQ_INSERT, 66,  '1, 0, 1, ple_pkg::ST_BADPOS, ple_pkg::DEPTH);
      add_row(ple_pkg::REQ_INSERT, 0,   '0, 0, 1, ple_pkg::ST_BADPOS, ple_pkg::DEPTH);
      add_row(ple_pkg::REQ_GET,    64,  '0, 0, 0, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_GET,    65,  '0, 0, 1, ple_pkg::ST_BADPOS, ple_pkg::DEPTH);
      add_row(ple_pkg::REQ_REMOVE, 64,  '0, 0, 0, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_REMOVE, 1,   '0, 0, 0, ple_pkg::ST_OK,     0);
      add_row(ple_pkg::REQ_INSERT, 63,  32'hC3C3_3C3C, 0, 0, ple_pkg::ST_OK, 0);
      add_row(ple_pkg::REQ_CLEAR,  64,  '0, 0, 1, ple_pkg::ST_OK,     0);

      repeat (2) @(posedge clock);
      reset <= 1'b0;

      // directed table
      foreach (directed_rows[i]) begin
         r = directed_rows[i];
         if (r.fill_first) begin
            while (list_count < ple_pkg::DEPTH)
               send_request(ple_pkg::REQ_INSERT, $urandom_range(1, list_count + 1),
                            ple_pkg::REC_W'($urandom), 1'b0, '0);
         end
         send_request(r.kind, r.pos, r.word, r.typed, r.result);
      end

      // random part, in three idling phases; the fill target moves every
      // 150 transactions and often lands on an extreme
      fill_target = ple_pkg::DEPTH;
      for (n = 0; n < RANDOM_ITEMS; n++) begin
         if (n == RANDOM_ITEMS / 3) begin
            send_idle_pct = 82;
            rcv_stall_pct = 7;
         end else if (n == 2 * RANDOM_ITEMS / 3) begin
            send_idle_pct = 0;
            rcv_stall_pct = 0;
         end
         if (n % 150 == 0 && n != 0) begin
            case ($urandom_range(0, 4))
               0:       fill_target = 0;
               1:       fill_target = 1;
               2:       fill_target = ple_pkg::DEPTH - 1;
               3:       fill_target = ple_pkg::DEPTH;
               default: fill_target = $urandom_range(2, ple_pkg::DEPTH - 2);
            endcase
         end
         send_random_request(fill_target);
      end
      req_valid <= 1'b0;

      // drain: every response in, then a quiet tail for strays
      while (awaited_responses.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      if (mismatch_count == 0 && awaited_responses.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

endmodule

// ===== positional_list_engine_unit.f =====
rtl/core/ple_pkg.sv
rtl/core/ple_ctrl.sv
rtl/core/ple_dp.sv
rtl/core/positional_list_engine_unit.sv
rtl/core/ple_checker.sv
test/positional_list_engine_unit_test.sv
